>>> rtl/keypad_button_qualifier_macros.svh
// Assertion macros for the keypad button qualifier.
// Depends on nothing; the asserting module supplies clock and reset by name.
`ifndef KEYPAD_BUTTON_QUALIFIER_MACROS_SVH
`define KEYPAD_BUTTON_QUALIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define KBQ_ASSERT_SAME(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("kbq: same-cycle check failed");
`define KBQ_ASSERT_NEXT(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("kbq: next-cycle check failed");
`else
`define KBQ_ASSERT_SAME(label, a, c)
`define KBQ_ASSERT_NEXT(label, a, c)
`endif
`endif

>>> rtl/kbq_pkg.sv
// Shared types and constants for the keypad button qualifier.
// Used by kbq_head and keypad_button_qualifier; depends on nothing.
package kbq_pkg;

   localparam int MASK_W  = 16;
   localparam int MODES_W = 32;
   localparam int CFG_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_PRESS   = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   localparam logic [1:0] MODE_UP    = 2'd0;
   localparam logic [1:0] MODE_DOWN  = 2'd1;
   localparam logic [1:0] MODE_DELAY = 2'd2;
   localparam logic [1:0] MODE_INERT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_BUTTON_MODES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_DELAY     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_PERIOD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS     = 2'd3;

   localparam logic [CFG_W-1:0] HOLD_DELAY_RESET    = 16'd1500;
   localparam logic [CFG_W-1:0] REPEAT_PERIOD_RESET = 16'd300;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET    = 16'd2000;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   typedef struct packed {
      logic act;
      logic click;
   } event_type;

endpackage

>>> rtl/kbq_cell.sv
// One button's state cell in the ring: held, repeating and hold timer.
// Hands its contents to the neighbor on every shift; no package use.
module kbq_cell #(
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic                  held_i,
   input  logic                  rep_i,
   input  logic [TIMER_BITS-1:0] timer_i,
   output logic                  held_o,
   output logic                  rep_o,
   output logic [TIMER_BITS-1:0] timer_o
);

   logic                  held_ff;
   logic                  rep_ff;
   logic [TIMER_BITS-1:0] timer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         rep_ff   <= 1'b0;
         timer_ff <= '0;
      end else if (shift_en) begin
         held_ff  <= held_i;
         rep_ff   <= rep_i;
         timer_ff <= timer_i;
      end
   end

   assign held_o  = held_ff;
   assign rep_o   = rep_ff;
   assign timer_o = timer_ff;

endmodule

>>> rtl/kbq_head.sv
// Update logic at the head of the ring: applies one transaction to one button.
// Depends on kbq_pkg for kind and mode codes and the event struct.
module kbq_head #(
   parameter int TIMER_BITS  = 16,
   parameter int CNT_W       = 4
) (
   input  logic [1:0]                    kind,
   input  logic [3:0]                    button_index,
   input  logic [CNT_W-1:0]              btn,
   input  logic [kbq_pkg::MODES_W-1:0]   button_modes,
   input  logic [kbq_pkg::CFG_W-1:0]     hold_delay,
   input  logic [kbq_pkg::CFG_W-1:0]     repeat_period,
   input  logic [kbq_pkg::CFG_W-1:0]     long_press,
   input  logic                          held_i,
   input  logic                          rep_i,
   input  logic [TIMER_BITS-1:0]         timer_i,
   output logic                          held_o,
   output logic                          rep_o,
   output logic [TIMER_BITS-1:0]         timer_o,
   output kbq_pkg::event_type            ev
);

   localparam int CMP_W = (TIMER_BITS > kbq_pkg::CFG_W) ? TIMER_BITS : kbq_pkg::CFG_W;

   logic [1:0]            mode;
   logic                  hit;
   logic [TIMER_BITS-1:0] timer_inc;
   logic [CMP_W-1:0]      inc_x;
   logic [CMP_W-1:0]      cur_x;

   always_comb begin
      mode = kbq_pkg::MODE_UP;
      if (int'(btn) < 16) begin
         mode = button_modes[2*int'(btn) +: 2];
      end
   end

   assign hit       = (int'(button_index) == int'(btn));
   assign timer_inc = (&timer_i) ? timer_i : timer_i + 1'b1;
   assign inc_x     = CMP_W'(timer_inc);
   assign cur_x     = CMP_W'(timer_i);

   always_comb begin
      held_o   = held_i;
      rep_o    = rep_i;
      timer_o  = timer_i;
      ev       = '0;
      unique case (kind)
         kbq_pkg::KIND_TICK: begin
            if (held_i) begin
               timer_o = timer_inc;
               if (mode == kbq_pkg::MODE_DOWN) begin
                  if (!rep_i) begin
                     if (inc_x > CMP_W'(hold_delay)) begin
                        rep_o   = 1'b1;
                        timer_o = '0;
                     end
                  end else if (inc_x >= CMP_W'(repeat_period)) begin
                     ev.act  = 1'b1;
                     timer_o = '0;
                  end
               end
            end
         end
         kbq_pkg::KIND_PRESS: begin
            if (hit && !held_i) begin
               held_o   = 1'b1;
               rep_o    = 1'b0;
               timer_o  = '0;
               ev.click = (mode != kbq_pkg::MODE_INERT);
               ev.act   = (mode == kbq_pkg::MODE_DOWN);
            end
         end
         kbq_pkg::KIND_RELEASE: begin
            if (hit && held_i) begin
               ev.act  = (mode == kbq_pkg::MODE_UP) ||
                         ((mode == kbq_pkg::MODE_DELAY) && (cur_x > CMP_W'(long_press)));
               held_o  = 1'b0;
               rep_o   = 1'b0;
               timer_o = '0;
            end
         end
         default: begin
            // unused kind: leave state alone
         end
      endcase
   end

endmodule

>>> rtl/keypad_button_qualifier.sv
// Keypad button qualifier: per-button press, release, auto-repeat and long-press logic.
// rsp_valid is registered and rises after the ring's last step for the accepted request.
// One transaction at a time: the state ring rotates once past its single update head, and
// the next request is taken only back in idle; a new request is taken while a response
// waits, and the ring holds on its last step until the response register frees up.
// Reset (synchronous): all buttons released, timers zero, config to its default values.
module keypad_button_qualifier #(
   parameter int NUM_BUTTONS = 16,
   parameter int TIMER_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_kind,
   input  logic [3:0]                      req_button_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [kbq_pkg::MASK_W-1:0]      rsp_activation_mask,
   output logic                            rsp_click,
   input  logic                            csr_wr_en,
   input  logic [kbq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kbq_pkg::MODES_W-1:0]     csr_wdata
);

`include "keypad_button_qualifier_macros.svh"

   localparam int CNT_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   kbq_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         kind_ff;
   logic [3:0]         idx_ff;
   logic [kbq_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic               click_ff, click_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [kbq_pkg::MASK_W-1:0] rsp_mask_ff;
   logic               rsp_click_ff;

   logic [kbq_pkg::MODES_W-1:0] modes_ff;
   logic [kbq_pkg::CFG_W-1:0]   hold_ff, period_ff, long_ff;

   logic                  cell_held  [NUM_BUTTONS];
   logic                  cell_rep   [NUM_BUTTONS];
   logic [TIMER_BITS-1:0] cell_timer [NUM_BUTTONS];
   logic                  head_held, head_rep;
   logic [TIMER_BITS-1:0] head_timer;
   kbq_pkg::event_type    ev;

   logic accept, running, last, out_free, shift_en, load;
   logic [kbq_pkg::MASK_W-1:0] act_bit;

   assign running   = (state_ff == kbq_pkg::ST_RUN);
   assign req_stall = !(state_ff == kbq_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign last      = (cnt_ff == CNT_W'(NUM_BUTTONS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // hold the ring on the final step until the response register frees up
   assign shift_en  = running && (!last || out_free);
   assign load      = shift_en && last;

   // head cell holds button cnt_ff; its updated state re-enters at the tail
   kbq_head #(
      .TIMER_BITS  (TIMER_BITS),
      .CNT_W       (CNT_W)
   ) u_head (
      .kind          (kind_ff),
      .button_index  (idx_ff),
      .btn           (cnt_ff),
      .button_modes  (modes_ff),
      .hold_delay    (hold_ff),
      .repeat_period (period_ff),
      .long_press    (long_ff),
      .held_i        (cell_held[0]),
      .rep_i         (cell_rep[0]),
      .timer_i       (cell_timer[0]),
      .held_o        (head_held),
      .rep_o         (head_rep),
      .timer_o       (head_timer),
      .ev            (ev)
   );

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_ring
      if (g == NUM_BUTTONS - 1) begin : g_tail
         kbq_cell #(.TIMER_BITS(TIMER_BITS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .held_i   (head_held),
            .rep_i    (head_rep),
            .timer_i  (head_timer),
            .held_o   (cell_held[g]),
            .rep_o    (cell_rep[g]),
            .timer_o  (cell_timer[g])
         );
      end else begin : g_body
         kbq_cell #(.TIMER_BITS(TIMER_BITS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .held_i   (cell_held[g+1]),
            .rep_i    (cell_rep[g+1]),
            .timer_i  (cell_timer[g+1]),
            .held_o   (cell_held[g]),
            .rep_o    (cell_rep[g]),
            .timer_o  (cell_timer[g])
         );
      end
   end

   assign act_bit = ev.act ? (kbq_pkg::MASK_W'(1) << cnt_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mask_in      = mask_ff;
      click_in     = click_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         state_in = kbq_pkg::ST_RUN;
         cnt_in   = '0;
         mask_in  = '0;
         click_in = 1'b0;
      end else if (shift_en) begin
         mask_in  = mask_ff | act_bit;
         click_in = click_ff | ev.click;
         if (last) begin
            state_in     = kbq_pkg::ST_IDLE;
            cnt_in       = '0;
            rsp_valid_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kbq_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         modes_ff     <= '0;
         hold_ff      <= kbq_pkg::HOLD_DELAY_RESET;
         period_ff    <= kbq_pkg::REPEAT_PERIOD_RESET;
         long_ff      <= kbq_pkg::LONG_PRESS_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               kbq_pkg::REG_BUTTON_MODES:  modes_ff  <= csr_wdata;
               kbq_pkg::REG_HOLD_DELAY:    hold_ff   <= csr_wdata[kbq_pkg::CFG_W-1:0];
               kbq_pkg::REG_REPEAT_PERIOD: period_ff <= csr_wdata[kbq_pkg::CFG_W-1:0];
               kbq_pkg::REG_LONG_PRESS:    long_ff   <= csr_wdata[kbq_pkg::CFG_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         idx_ff  <= req_button_index;
      end
      mask_ff  <= mask_in;
      click_ff <= click_in;
      if (load) begin
         rsp_mask_ff  <= mask_in;
         rsp_click_ff <= click_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_activation_mask = rsp_mask_ff;
   assign rsp_click           = rsp_click_ff;

   `KBQ_ASSERT_NEXT(a_accept_runs, accept, running && (cnt_ff == '0))
   `KBQ_ASSERT_SAME(a_idle_cnt_zero, !running, cnt_ff == '0)
   `KBQ_ASSERT_NEXT(a_load_presents, load, rsp_valid_ff && !running)
   `KBQ_ASSERT_SAME(a_no_overwrite, load, out_free)

endmodule

>>> test/kbq_response_checker.sv
// Response checker for the keypad button qualifier testbench.
// Watches the request, response and CSR ports, predicts each response and compares.
// Depends on kbq_pkg for kinds, modes, register indexes and reset values.
`timescale 1ns / 1ps

module kbq_response_checker
   import kbq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [1:0]             req_kind,
   input  logic [3:0]             req_button_index,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [MASK_W-1:0]      rsp_activation_mask,
   input  logic                   rsp_click,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [MODES_W-1:0]     csr_wdata,
   output int unsigned            mismatches,
   output int unsigned            outstanding
);

   localparam int BUTTONS = 16;
   localparam int TIMER_W = 16;

   typedef struct packed {
      logic [MASK_W-1:0] activation_mask;
      logic              click;
   } qualified_type;

   logic [MODES_W-1:0] cur_modes;
   logic [CFG_W-1:0]   hold_delay;
   logic [CFG_W-1:0]   repeat_period;
   logic [CFG_W-1:0]   long_press;

   logic [BUTTONS-1:0] held;
   logic [BUTTONS-1:0] repeating;
   logic [TIMER_W-1:0] hold_timer [BUTTONS];

   qualified_type awaited_responses [$];
   int unsigned   fail_count;

   initial begin
      fail_count  = 0;
      mismatches  = 0;
      outstanding = 0;
   end

   // Advance the button state by one transaction and return what it should produce.
   function automatic qualified_type qualify_event(input logic [1:0] kind,
                                                    input logic [3:0] idx);
      qualified_type r;
      logic [1:0]    m;
      r = '0;
      m = cur_modes[2*idx +: 2];
      case (kind)
         KIND_TICK: begin
            for (int i = 0; i < BUTTONS; i++) begin
               if (held[i]) begin
                  if (hold_timer[i] != '1) hold_timer[i] = hold_timer[i] + 1'b1;
                  if (cur_modes[2*i +: 2] == MODE_DOWN) begin
                     if (!repeating[i]) begin
                        if (hold_timer[i] > hold_delay) begin
                           repeating[i]  = 1'b1;
                           hold_timer[i] = '0;
                        end
                     end else if (hold_timer[i] >= repeat_period) begin
                        r.activation_mask[i] = 1'b1;
                        hold_timer[i]        = '0;
                     end
                  end
               end
            end
         end
         KIND_PRESS: begin
            if (!held[idx]) begin
               held[idx]       = 1'b1;
               repeating[idx]  = 1'b0;
               hold_timer[idx] = '0;
               r.click         = (m != MODE_INERT);
               if (m == MODE_DOWN) r.activation_mask[idx] = 1'b1;
            end
         end
         KIND_RELEASE: begin
            if (held[idx]) begin
               if (m == MODE_UP) r.activation_mask[idx] = 1'b1;
               else if (m == MODE_DELAY && hold_timer[idx] > long_press)
                  r.activation_mask[idx] = 1'b1;
               held[idx]       = 1'b0;
               repeating[idx]  = 1'b0;
               hold_timer[idx] = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      qualified_type want;
      if (reset) begin
         cur_modes     = '0;
         hold_delay    = HOLD_DELAY_RESET;
         repeat_period = REPEAT_PERIOD_RESET;
         long_press    = LONG_PRESS_RESET;
         held          = '0;
         repeating     = '0;
         for (int i = 0; i < BUTTONS; i++) hold_timer[i] = '0;
         awaited_responses.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_BUTTON_MODES:  cur_modes     = csr_wdata;
               REG_HOLD_DELAY:    hold_delay    = csr_wdata[CFG_W-1:0];
               REG_REPEAT_PERIOD: repeat_period = csr_wdata[CFG_W-1:0];
               REG_LONG_PRESS:    long_press    = csr_wdata[CFG_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("response transaction with nothing outstanding: mask %h click %b",
                      rsp_activation_mask, rsp_click);
               fail_count++;
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_activation_mask !== want.activation_mask) begin
                  $error("activation_mask: expected %h, got %h",
                         want.activation_mask, rsp_activation_mask);
                  fail_count++;
               end
               if (rsp_click !== want.click) begin
                  $error("click: expected %b, got %b", want.click, rsp_click);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_responses.push_back(qualify_event(req_kind, req_button_index));
      end
      mismatches  <= fail_count;
      outstanding <= awaited_responses.size();
   end

endmodule

>>> test/tb_top.sv
// Top of the keypad button qualifier testbench: clock, reset, stimulus and verdict.
// Depends on kbq_pkg, keypad_button_qualifier and kbq_response_checker.
`timescale 1ns / 1ps

module tb_top;
   import kbq_pkg::*;

   localparam logic [1:0] KIND_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT   = 1000000;
   localparam int         FREEZE_CYCLES = 400;
   localparam int         SETTLE_CYCLES = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_kind;
   logic [3:0]           req_button_index;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [MASK_W-1:0]    rsp_activation_mask;
   logic                 rsp_click;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MODES_W-1:0]   csr_wdata;
   int unsigned          mismatches;
   int unsigned          outstanding;

   logic                 rsp_freeze;
   logic                 rsp_quiet;
   logic                 send_quiet;
   logic [15:0]          pressed;
   int unsigned          cycle_count;

   keypad_button_qualifier uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_button_index    (req_button_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_activation_mask (rsp_activation_mask),
      .rsp_click           (rsp_click),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   kbq_response_checker response_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_button_index    (req_button_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_activation_mask (rsp_activation_mask),
      .rsp_click           (rsp_click),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatches          (mismatches),
      .outstanding         (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Response side: random stall runs, one long freeze on request.
   initial begin : rsp_side
      int unsigned run_left;
      int unsigned r;
      logic        level;
      logic        freeze_taken;
      run_left     = 0;
      level        = 1'b0;
      freeze_taken = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (run_left == 0) begin
            r = $urandom_range(0, 99);
            if (rsp_freeze && !freeze_taken) begin
               freeze_taken = 1'b1;
               level        = 1'b1;
               run_left     = FREEZE_CYCLES;
            end else if (rsp_quiet || r < 50) begin
               level    = 1'b0;
               run_left = $urandom_range(1, 16);
            end else if (r < 90) begin
               level    = 1'b1;
               run_left = $urandom_range(1, 3);
            end else if (r < 97) begin
               level    = 1'b1;
               run_left = $urandom_range(4, 12);
            end else begin
               level    = 1'b1;
               run_left = $urandom_range(20, 60);
            end
         end
         run_left--;
         rsp_stall <= level;
      end
   end

   // Offer one transaction, hold it until accepted, then maybe idle a while.
   task automatic offer_event(input logic [1:0] kind, input logic [3:0] idx);
      int unsigned r;
      int unsigned gap;
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_button_index <= idx;
      if (kind == KIND_PRESS) pressed[idx] = 1'b1;
      if (kind == KIND_RELEASE) pressed[idx] = 1'b0;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = $urandom_range(0, 99);
      if (send_quiet || r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 50);
      if (gap != 0) begin
         req_valid        <= 1'b0;
         req_kind         <= 2'($urandom);
         req_button_index <= 4'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic load_settings(input logic [MODES_W-1:0] modes,
                                input logic [CFG_W-1:0] hold,
                                input logic [CFG_W-1:0] period,
                                input logic [CFG_W-1:0] long_hold);
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_BUTTON_MODES;
      csr_wdata <= modes;
      @(posedge clock);
      csr_index <= REG_HOLD_DELAY;
      csr_wdata <= {16'($urandom), hold};
      @(posedge clock);
      csr_index <= REG_REPEAT_PERIOD;
      csr_wdata <= {16'($urandom), period};
      @(posedge clock);
      csr_index <= REG_LONG_PRESS;
      csr_wdata <= {16'($urandom), long_hold};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned        items;
      int unsigned        r;
      logic [3:0]         b;
      logic [MODES_W-1:0] modes;
      logic [CFG_W-1:0]   hold;
      logic [CFG_W-1:0]   period;
      logic [CFG_W-1:0]   long_hold;
      pressed    = '0;
      send_quiet = 1'b0;
      rsp_freeze       <= 1'b0;
      rsp_quiet        <= 1'b0;
      req_valid        <= 1'b0;
      req_kind         <= KIND_TICK;
      req_button_index <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= REG_BUTTON_MODES;
      csr_wdata        <= '0;
      reset            <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: every button is up type.
      offer_event(KIND_PRESS, 4'd0);
      offer_event(KIND_RELEASE, 4'd0);
      offer_event(KIND_RELEASE, 4'd0);   // not held
      offer_event(KIND_PRESS, 4'd15);
      offer_event(KIND_PRESS, 4'd15);    // already held
      offer_event(KIND_UNUSED, 4'd15);
      offer_event(KIND_RELEASE, 4'd15);

      // Buttons cycle up, down, delay, inert.
      load_settings(32'hE4E4_E4E4, 16'd2, 16'd1, 16'd1);
      offer_event(KIND_PRESS, 4'd1);
      repeat (5) offer_event(KIND_TICK, 4'd0);   // enter repeat, then two repeats
      offer_event(KIND_PRESS, 4'd2);
      offer_event(KIND_TICK, 4'd9);
      offer_event(KIND_RELEASE, 4'd2);           // short hold on delay type
      offer_event(KIND_PRESS, 4'd2);
      offer_event(KIND_TICK, 4'd0);
      offer_event(KIND_TICK, 4'd0);
      offer_event(KIND_RELEASE, 4'd2);           // long hold on delay type
      offer_event(KIND_PRESS, 4'd3);
      offer_event(KIND_RELEASE, 4'd3);
      offer_event(KIND_RELEASE, 4'd1);
      offer_event(KIND_PRESS, 4'd12);
      offer_event(KIND_RELEASE, 4'd12);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin modes = 32'h5555_5555; hold = 16'd1;     period = 16'd0;
                     long_hold = 16'd1; end
            1: begin modes = 32'hAAAA_AAAA; hold = 16'hFFFF;  period = 16'hFFFF;
                     long_hold = 16'd0; end
            2: begin modes = 32'hFFFF_FFFF; hold = 16'd0;     period = 16'd1;
                     long_hold = 16'hFFFF; end
            3: begin modes = 32'h0000_0000; hold = 16'hFFFF;  period = 16'd1;
                     long_hold = 16'd1; end
            default: begin
               modes     = $urandom;
               hold      = 16'($urandom_range(0, 10));
               period    = 16'($urandom_range(0, 6));
               long_hold = 16'($urandom_range(0, 12));
            end
         endcase
         load_settings(modes, hold, period, long_hold);
         if (phase == 5) rsp_freeze <= 1'b1;
         rsp_quiet <= (phase == 6);
         for (items = 0; items < ((phase < 4) ? 100 : 300); items++) begin
            send_quiet = (phase == 6) || (phase == 5 && items < 40);
            if (phase == 7 && items == 150) drain_responses();
            r = $urandom_range(0, 99);
            b = 4'($urandom);
            if (r < 48) begin
               offer_event(KIND_TICK, b);
            end else if (r < 74) begin
               // mostly press a button that is free
               if (r < 71)
                  for (int n = 0; n < 16 && pressed[b]; n++) b = b + 1'b1;
               offer_event(KIND_PRESS, b);
            end else if (r < 95) begin
               // mostly release a button that is held
               if (r < 92)
                  for (int n = 0; n < 16 && !pressed[b]; n++) b = b + 1'b1;
               offer_event(KIND_RELEASE, b);
            end else begin
               offer_event(KIND_UNUSED, b);
            end
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
